>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Each expects clk_i in scope; ASSERT_RST also expects rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALW(lbl, prop, msg)
`endif
`endif

>>> design/mcpg_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint circle package
// Field widths, codes and the job word passed from the front to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpg_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned RAD_W   = 11;
  localparam int unsigned STEP_W  = 12;
  localparam int unsigned DEC_W   = 14;
  localparam int unsigned PT_W    = 14;
  localparam int unsigned COL_W   = 8;
  localparam int unsigned IDX_W   = 3;

  // Input action codes.
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // Kind of work queued for the back part.
  typedef enum logic [1:0] {
    JOB_START = 2'd0,
    JOB_LOOP  = 2'd1,
    JOB_DONE  = 2'd2
  } job_kind_e;

  // One queued job: everything needed to expand an item into its words.
  typedef struct packed {
    job_kind_e           kind;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [RAD_W-1:0]    x;
    logic [STEP_W-1:0]   y;
    logic [COL_W-1:0]    color;
    logic                preserve;
  } job_t;

  // Index of the final output word of a job.
  function automatic logic [IDX_W-1:0] last_index(job_kind_e kind);
    logic [IDX_W-1:0] idx;
    case (kind)
      JOB_START: idx = IDX_W'(3);
      JOB_LOOP:  idx = IDX_W'(7);
      default:   idx = '0;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> design/mcpg_intf.sv
// ----------------------------------------------------------------------------
// Midpoint circle channels
// Valid/ready channels for input items and for plotted point words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcpg_in_if ();
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [mcpg_pkg::COORD_W-1:0] center_x;
  logic [mcpg_pkg::COORD_W-1:0] center_y;
  logic [mcpg_pkg::RAD_W-1:0]   radius;
  logic [mcpg_pkg::COL_W-1:0]   color;
  logic                         preserve_color;

  modport source (
    output valid, action, center_x, center_y, radius, color, preserve_color,
    input  ready
  );
  modport sink (
    input  valid, action, center_x, center_y, radius, color, preserve_color,
    output ready
  );
endinterface

interface mcpg_out_if ();
  logic                             valid;
  logic                             ready;
  logic signed [mcpg_pkg::PT_W-1:0] point_x;
  logic signed [mcpg_pkg::PT_W-1:0] point_y;
  logic [mcpg_pkg::COL_W-1:0]       point_color;
  logic                             point_preserve;
  logic                             point_valid;
  logic                             circle_done;
  logic                             last_of_run;

  modport source (
    output valid, point_x, point_y, point_color, point_preserve, point_valid,
           circle_done, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_color, point_preserve, point_valid,
           circle_done, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

>>> design/mcpg_front.sv
// ----------------------------------------------------------------------------
// Midpoint circle front part
// Accepts input words, runs the midpoint decision step and queues one job.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mcpg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  mcpg_in_if.sink         in_i,
  output mcpg_pkg::job_t  job_o,
  output logic            push_o,
  input  logic            full_i
);
  import mcpg_pkg::*;

  logic [COORD_W-1:0] cx_q, cx_d;
  logic [COORD_W-1:0] cy_q, cy_d;
  logic [RAD_W-1:0]   x_q, x_d;
  logic [STEP_W-1:0]  y_q, y_d;
  logic [DEC_W-1:0]   p_q, p_d;
  logic [COL_W-1:0]   pen_q, pen_d;
  logic               keep_q, keep_d;
  logic               run_q, run_d;

  logic               accept;
  logic signed [12:0] x_s, y_s, x_dec, x_n;
  logic [DEC_W-1:0]   p_neg, p_pos, p_n;
  job_t               job;

  // A word is taken whenever the queue has room.
  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept;
  assign job_o      = job;

  // One midpoint step on the stored state. Decision arithmetic wraps at 14 bits.
  assign x_s   = signed'({2'b00, x_q});
  assign y_s   = signed'({1'b0, y_q});
  assign x_dec = x_s - 13'sd1;
  assign p_neg = p_q + {1'b0, y_q, 1'b0} + DEC_W'(1);
  assign p_pos = p_q + {1'b0, y_q, 1'b0} - {2'b00, x_q, 1'b0} + DEC_W'(3);
  assign x_n   = p_q[DEC_W-1] ? x_s : x_dec;
  assign p_n   = p_q[DEC_W-1] ? p_neg : p_pos;

  // Build the job and the next state for the word on the input.
  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    x_d    = x_q;
    y_d    = y_q;
    p_d    = p_q;
    pen_d  = pen_q;
    keep_d = keep_q;
    run_d  = run_q;
    job    = '{kind: JOB_DONE, default: '0};
    unique case (in_i.action)
      ACT_START: begin
        cx_d   = in_i.center_x;
        cy_d   = in_i.center_y;
        x_d    = in_i.radius;
        y_d    = '0;
        p_d    = DEC_W'(1) - {3'b000, in_i.radius};
        pen_d  = in_i.color;
        keep_d = in_i.preserve_color;
        run_d  = 1'b1;
        job    = '{kind: JOB_START, cx: in_i.center_x, cy: in_i.center_y,
                   x: in_i.radius, y: '0, color: in_i.color, preserve: 1'b0};
      end
      ACT_ADVANCE: begin
        if (!run_q || (x_s < y_s)) begin
          run_d = 1'b0;
        end else begin
          p_d = p_n;
          x_d = x_n[RAD_W-1:0];
          if (x_n < y_s) begin
            run_d = 1'b0;
          end else begin
            y_d = y_q + STEP_W'(1);
            job = '{kind: JOB_LOOP, cx: cx_q, cy: cy_q, x: x_n[RAD_W-1:0],
                    y: y_q, color: pen_q, preserve: keep_q};
          end
        end
      end
      default: begin
        run_d = run_q;
      end
    endcase
  end

  // Circle state, updated once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      x_q    <= '0;
      y_q    <= '0;
      p_q    <= '0;
      pen_q  <= '0;
      keep_q <= 1'b0;
      run_q  <= 1'b0;
    end else if (accept) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      x_q    <= x_d;
      y_q    <= y_d;
      p_q    <= p_d;
      pen_q  <= pen_d;
      keep_q <= keep_d;
      run_q  <= run_d;
    end
  end

  // A job that plots points always leaves a circle running.
  `ASSERT_RST(a_points_leave_run, push_o && job.kind != JOB_DONE |=> run_q, "point job without run")

endmodule

`default_nettype wire

>>> design/mcpg_fifo.sv
// ----------------------------------------------------------------------------
// Midpoint circle job queue
// Short register queue between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mcpg_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mcpg_pkg::job_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output mcpg_pkg::job_t  data_o,
  output logic            empty_o
);
  import mcpg_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `ASSERT_ALW(a_count_bound, count_q <= CntW'(DEPTH), "queue fill count past depth")

endmodule

`default_nettype wire

>>> design/mcpg_back.sv
// ----------------------------------------------------------------------------
// Midpoint circle back part
// Expands each queued job into point words, one per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mcpg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mcpg_pkg::job_t  head_i,
  input  logic            empty_i,
  output logic            pop_o,
  mcpg_out_if.source      out_o
);
  import mcpg_pkg::*;

  logic             ovalid_q;
  logic [IDX_W-1:0] idx_q;
  logic [PT_W-1:0]  px_q, px_d;
  logic [PT_W-1:0]  py_q, py_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             pres_q, pres_d;
  logic             pval_q, pval_d;
  logic             done_q, done_d;
  logic             last_q;

  logic             out_free, take, is_last;
  logic [STEP_W-1:0] a_term, b_term;
  logic [PT_W-1:0]  a_off, b_off;

  // The output register frees when empty or when its word is taken.
  assign out_free = !ovalid_q || out_o.ready;
  assign take     = !empty_i && out_free;
  assign is_last  = (idx_q == last_index(head_i.kind));
  assign pop_o    = take && is_last;

  // Octant select: bit 2 swaps the axes, bit 0 negates x, bit 1 negates y.
  assign a_term = idx_q[2] ? head_i.y : {1'b0, head_i.x};
  assign b_term = idx_q[2] ? {1'b0, head_i.x} : head_i.y;
  assign a_off  = {2'b00, a_term};
  assign b_off  = {2'b00, b_term};

  always_comb begin
    px_d   = '0;
    py_d   = '0;
    col_d  = '0;
    pres_d = 1'b0;
    pval_d = 1'b0;
    done_d = 1'b1;
    if (head_i.kind != JOB_DONE) begin
      px_d   = {2'b00, head_i.cx} + (idx_q[0] ? -a_off : a_off);
      py_d   = {2'b00, head_i.cy} + (idx_q[1] ? -b_off : b_off);
      col_d  = head_i.color;
      pres_d = head_i.preserve;
      pval_d = 1'b1;
      done_d = 1'b0;
    end
  end

  // Control: output valid and word index within the current job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      idx_q    <= '0;
    end else if (take) begin
      ovalid_q <= 1'b1;
      idx_q    <= is_last ? '0 : idx_q + IDX_W'(1);
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      px_q   <= px_d;
      py_q   <= py_d;
      col_q  <= col_d;
      pres_q <= pres_d;
      pval_q <= pval_d;
      done_q <= done_d;
      last_q <= is_last;
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.point_x        = signed'(px_q);
  assign out_o.point_y        = signed'(py_q);
  assign out_o.point_color    = col_q;
  assign out_o.point_preserve = pres_q;
  assign out_o.point_valid    = pval_q;
  assign out_o.circle_done    = done_q;
  assign out_o.last_of_run    = last_q;

  `ASSERT_RST(a_idx_in_job, !empty_i |-> idx_q <= last_index(head_i.kind), "word index past job")
  `ASSERT_RST(a_pop_rewinds, pop_o |=> idx_q == '0, "index not rewound after job")

endmodule

`default_nettype wire

>>> design/midpoint_circle_point_generator.sv
// Midpoint circle point generator. A start word loads centre, radius, colour
// and preserve flag and yields four axis point words; each advance word runs
// one midpoint step and yields eight symmetric point words, or a single done
// word once the circle has finished. Result words leave one per cycle from a
// registered output while jobs wait and out_o.ready holds, so a start item
// fills four output words and an advance item eight (one when it ends the
// circle); the output port sets the sustained rate of advance items. The
// front accepts one input word per cycle while the QUEUE_DEPTH-entry job
// queue has room, so input and output stall independently. An accepted item
// is written into the job queue, and its first word is then loaded from the
// queue head into the output register once that register is free or read.
// ----------------------------------------------------------------------------
// Midpoint circle point generator, top level
// Front decision step, job queue and point expansion back part.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_point_generator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcpg_in_if.sink     in_i,
  mcpg_out_if.source  out_o
);
  import mcpg_pkg::*;

  job_t front_job, head_job;
  logic push, full, pop, empty;

  // Front: decision step and state.
  mcpg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .job_o  (front_job),
    .push_o (push),
    .full_i (full)
  );

  // Job queue between the two parts.
  mcpg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (empty)
  );

  // Back: point word expansion.
  mcpg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_job),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
